// ===== hw/rtl/temperature_drop_lid_detector_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Lid detector assertion macros
// Shared property wrappers for the lid detector checkers.
// ----------------------------------------------------------------------------
`ifndef TEMPERATURE_DROP_LID_DETECTOR_UNIT_MACROS_SVH
`define TEMPERATURE_DROP_LID_DETECTOR_UNIT_MACROS_SVH

// same-cycle implication
`define TDL_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lid detector check failed");

// next-cycle implication
`define TDL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lid detector check failed");

`endif

// ===== hw/rtl/tdl_pkg.sv =====
// ----------------------------------------------------------------------------
// Lid detector package
// Shared types and constants of the temperature drop lid detector.
// ----------------------------------------------------------------------------
package tdl_pkg;

    localparam int SAMPLE_PERIOD_MS = 2000;
    localparam int CEIL_MARGIN      = 160;
    localparam int RECOVER_MARGIN   = 32;
    localparam int THR_W            = 15;
    localparam int TIME_W           = 32;
    localparam int APB_ADDR_W       = 3;
    localparam int APB_DATA_W       = 32;
    localparam int M_DATA_W         = 8;

    localparam logic REG_DROP_THRESHOLD   = 1'b0;
    localparam logic REG_RECOVERY_TIMEOUT = 1'b1;

    localparam logic [THR_W-1:0]  DROP_THRESHOLD_RST = 15'd160;
    localparam logic [TIME_W-1:0] RECOVERY_TIMEOUT_RST = 32'd300000;

    typedef enum logic [1:0] {
        EV_NONE      = 2'd0,
        EV_OPENED    = 2'd1,
        EV_TIMEOUT   = 2'd2,
        EV_RECOVERED = 2'd3
    } event_t;

    typedef struct packed {
        logic fill;
        logic push;
    } cell_ctrl_t;

endpackage

// ===== hw/rtl/tdl_cell.sv =====
// ----------------------------------------------------------------------------
// Lid detector sample cell
// One stage of the sample history: loads on fill, takes its neighbor on push.
// ----------------------------------------------------------------------------
module tdl_cell #(
    parameter int W = 16
) (
    input  logic                 aclk,
    input  tdl_pkg::cell_ctrl_t  ctrl,
    input  logic [W-1:0]         fill_data,
    input  logic [W-1:0]         prev_data,
    output logic [W-1:0]         cell_data
);

    logic [W-1:0] sample_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.fill) begin
            sample_reg <= fill_data;
        end else if (ctrl.push) begin
            sample_reg <= prev_data;
        end
    end

    assign cell_data = sample_reg;

endmodule

// ===== hw/rtl/tdl_chain.sv =====
// ----------------------------------------------------------------------------
// Lid detector sample chain
// Row of sample cells; the last cell holds the oldest sample of the window.
// ----------------------------------------------------------------------------
module tdl_chain #(
    parameter int DEPTH = 15,
    parameter int W     = 16
) (
    input  logic                 aclk,
    input  tdl_pkg::cell_ctrl_t  ctrl,
    input  logic [W-1:0]         sample_in,
    output logic [W-1:0]         oldest
);

    localparam int NCELLS = DEPTH - 1;

    logic [W-1:0] tap [NCELLS+1];

    assign tap[0] = sample_in;

    for (genvar i = 0; i < NCELLS; i++) begin : g_cell
        tdl_cell #(
            .W(W)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .fill_data (sample_in),
            .prev_data (tap[i]),
            .cell_data (tap[i+1])
        );
    end

    assign oldest = tap[NCELLS];

endmodule

// ===== hw/rtl/temperature_drop_lid_detector_unit.sv =====
// ----------------------------------------------------------------------------
// Temperature drop lid detector
// Flags an open lid from a temperature fall over a window of stored samples.
// ----------------------------------------------------------------------------
// Takes one request per clock while the output is not stalled and returns its
// result in the next cycle through an output register, computed by the
// combinational compare path from the last cell of the sample chain. The first
// request after reset loads the whole chain with its temperature; no clearing
// pass is needed. With the output stalled the block still takes a request
// while the output register is being drained in the same cycle.
module temperature_drop_lid_detector_unit #(
    parameter int RING_DEPTH = 15,
    parameter int TEMP_BITS  = 16
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    // request: temperature, target_temp, now_ms (low bits first)
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    input  logic [((2*TEMP_BITS+32+7)/8)*8-1:0]      s_tdata,
    // result: lid_open, event_res (low bits first)
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    output logic [tdl_pkg::M_DATA_W-1:0]             m_tdata,
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [tdl_pkg::APB_ADDR_W-1:0]           paddr,
    input  logic [tdl_pkg::APB_DATA_W-1:0]           pwdata,
    output logic [tdl_pkg::APB_DATA_W-1:0]           prdata,
    output logic                                     pready
);

    localparam int TW    = tdl_pkg::TIME_W;
    localparam int CMP_W = (TEMP_BITS > 15) ? TEMP_BITS + 2 : 17;

    logic [TEMP_BITS-1:0] temp_in;
    logic [TEMP_BITS-1:0] target_in;
    logic [TW-1:0]        now_in;
    logic [TEMP_BITS-1:0] oldest;

    logic                        baseline_ready_reg;
    logic [TW-1:0]               last_sample_reg;
    logic [TW-1:0]               open_since_reg;
    logic                        open_flag_reg;
    logic [tdl_pkg::THR_W-1:0]   thr_reg;
    logic [TW-1:0]               timeout_reg;
    logic                        m_tvalid_reg;
    logic [tdl_pkg::M_DATA_W-1:0] m_tdata_reg;

    logic                        open_flag_next;
    tdl_pkg::event_t             event_next;
    logic [tdl_pkg::M_DATA_W-1:0] m_tdata_next;

    logic                 accept;
    logic                 cfg_write;
    logic [TW-1:0]        elapsed;
    logic                 sample_due;
    logic signed [CMP_W-1:0] temp_x;
    logic signed [CMP_W-1:0] target_x;
    logic signed [CMP_W-1:0] oldest_x;
    logic signed [CMP_W-1:0] thr_x;
    logic signed [CMP_W-1:0] drop_x;
    logic                 drop_hit;
    logic                 below_ceiling;
    logic                 recovered;
    logic                 opened;
    logic                 open_mid;
    logic [TW-1:0]        since_eff;
    logic                 timed_out;
    tdl_pkg::cell_ctrl_t  chain_ctrl;

    assign temp_in   = s_tdata[TEMP_BITS-1:0];
    assign target_in = s_tdata[2*TEMP_BITS-1:TEMP_BITS];
    assign now_in    = s_tdata[2*TEMP_BITS+TW-1:2*TEMP_BITS];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    tdl_chain #(
        .DEPTH (RING_DEPTH),
        .W     (TEMP_BITS)
    ) u_chain (
        .aclk      (aclk),
        .ctrl      (chain_ctrl),
        .sample_in (temp_in),
        .oldest    (oldest)
    );

    always_comb begin
        elapsed    = now_in - last_sample_reg;
        sample_due = baseline_ready_reg && (elapsed >= TW'(tdl_pkg::SAMPLE_PERIOD_MS));

        temp_x   = {{(CMP_W-TEMP_BITS){temp_in[TEMP_BITS-1]}}, temp_in};
        target_x = {{(CMP_W-TEMP_BITS){target_in[TEMP_BITS-1]}}, target_in};
        oldest_x = {{(CMP_W-TEMP_BITS){oldest[TEMP_BITS-1]}}, oldest};
        thr_x    = {{(CMP_W-tdl_pkg::THR_W){1'b0}}, thr_reg};
        drop_x   = oldest_x - temp_x;

        drop_hit      = drop_x >= thr_x;
        below_ceiling = temp_x < (target_x + CMP_W'(tdl_pkg::CEIL_MARGIN));
        recovered     = temp_x >= (target_x - CMP_W'(tdl_pkg::RECOVER_MARGIN));

        opened    = sample_due && !open_flag_reg && drop_hit && below_ceiling;
        open_mid  = open_flag_reg || opened;
        since_eff = opened ? now_in : open_since_reg;
        timed_out = (now_in - since_eff) > timeout_reg;

        chain_ctrl.fill = accept && !baseline_ready_reg;
        chain_ctrl.push = accept && sample_due;
    end

    always_comb begin
        event_next     = opened ? tdl_pkg::EV_OPENED : tdl_pkg::EV_NONE;
        open_flag_next = open_mid;
        if (open_mid && timed_out) begin
            event_next     = tdl_pkg::EV_TIMEOUT;
            open_flag_next = 1'b0;
        end
        if (open_mid && recovered) begin
            event_next     = tdl_pkg::EV_RECOVERED;
            open_flag_next = 1'b0;
        end
        m_tdata_next = {{(tdl_pkg::M_DATA_W-3){1'b0}}, event_next, open_flag_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            baseline_ready_reg <= 1'b0;
            last_sample_reg    <= '0;
            open_since_reg     <= '0;
            open_flag_reg      <= 1'b0;
        end else if (accept) begin
            baseline_ready_reg <= 1'b1;
            if (!baseline_ready_reg || sample_due) begin
                last_sample_reg <= now_in;
            end
            if (opened) begin
                open_since_reg <= now_in;
            end
            open_flag_reg <= open_flag_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_tready) begin
            m_tvalid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg     <= tdl_pkg::DROP_THRESHOLD_RST;
            timeout_reg <= tdl_pkg::RECOVERY_TIMEOUT_RST;
        end else if (cfg_write) begin
            case (paddr[2])
                tdl_pkg::REG_DROP_THRESHOLD: begin
                    thr_reg <= pwdata[tdl_pkg::THR_W-1:0];
                end
                tdl_pkg::REG_RECOVERY_TIMEOUT: begin
                    timeout_reg <= pwdata[TW-1:0];
                end
                default: begin
                    thr_reg <= thr_reg;
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            tdl_pkg::REG_DROP_THRESHOLD: begin
                prdata = {{(tdl_pkg::APB_DATA_W-tdl_pkg::THR_W){1'b0}}, thr_reg};
            end
            tdl_pkg::REG_RECOVERY_TIMEOUT: begin
                prdata = timeout_reg;
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/tdl_checker.sv =====
// ----------------------------------------------------------------------------
// Lid detector port checker
// Watches the ports of the lid detector for handshake and result consistency.
// ----------------------------------------------------------------------------
`include "temperature_drop_lid_detector_unit_macros.svh"

module tdl_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    input  logic                                 s_tready,
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic [tdl_pkg::M_DATA_W-1:0]         m_tdata
);

    logic       out_busy;
    logic [1:0] ev;
    logic       in_seen;
    logic       ev_open;
    logic       ev_clear;

    assign out_busy = m_tvalid && !m_tready;
    assign ev       = m_tdata[2:1];
    assign in_seen  = s_tvalid && s_tready;
    assign ev_open  = m_tvalid && (ev == tdl_pkg::EV_OPENED);
    assign ev_clear = m_tvalid &&
                      ((ev == tdl_pkg::EV_TIMEOUT) || (ev == tdl_pkg::EV_RECOVERED));

    `TDL_ASSERT_NEXT(a_hold_result, aclk, aresetn, out_busy, m_tvalid && $stable(m_tdata))
    `TDL_ASSERT_NEXT(a_request_yields_result, aclk, aresetn, in_seen, m_tvalid)
    `TDL_ASSERT_NOW(a_ready_when_empty, aclk, aresetn, !m_tvalid, s_tready)
    `TDL_ASSERT_NOW(a_opened_sets_flag, aclk, aresetn, ev_open, m_tdata[0])
    `TDL_ASSERT_NOW(a_clear_drops_flag, aclk, aresetn, ev_clear, !m_tdata[0])

endmodule

bind temperature_drop_lid_detector_unit tdl_checker u_tdl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
